[rtl/hon_pkg.sv]
// Package for the one-letter-neighbor word filter: sizes, request and
// result structs, cell and chain control types, state codes.
// No dependencies.
`default_nettype none

package hon_pkg;

	localparam int MAX_WORDS   = 64;
	localparam int MAX_LETTERS = 10;
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = MAX_LETTERS * BYTE_W;
	localparam int LEN_W       = 4;
	localparam int CNT_W       = $clog2(MAX_WORDS + 1);
	localparam int IDX_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(5);

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [63:0] word_low;
		logic [15:0] word_high;
		logic [3:0]  word_letters;
	} in_req_t;

	typedef struct packed {
		logic        is_word;
		logic [63:0] out_low;
		logic [15:0] out_high;
		logic [6:0]  removed_count;
		logic        overflowed;
		logic        last;
	} out_rsp_t;

	// word moving down the chain, looking for a free slot
	typedef struct packed {
		logic                   valid;
		logic                   found;
		logic [MAX_LETTERS-1:0] mask;
		logic [WORD_W-1:0]      word;
	} entry_t;

	// word resting in a slot
	typedef struct packed {
		logic              valid;
		logic              nbr;
		logic [WORD_W-1:0] word;
	} slot_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic rotate;
	} chain_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_COUNT,
		ST_EMIT
	} state_t;

	// one bit per letter position below len
	function automatic logic [MAX_LETTERS-1:0] byte_mask(input logic [LEN_W-1:0] len);
		logic [MAX_LETTERS-1:0] m;
		m = '0;
		for (int b = 0; b < MAX_LETTERS; b++) begin
			m[b] = (LEN_W'(b) < len);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

[rtl/hon_cell.sv]
// One slot of the word chain: holds a stored word and its neighbor mark,
// and checks a passing word for a one-letter difference. Uses hon_pkg.
`default_nettype none

module hon_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  hon_pkg::chain_ctl_t ctl,
	input  hon_pkg::entry_t     trav_in,
	output hon_pkg::entry_t     trav_out,
	input  hon_pkg::slot_t      next_slot,
	output hon_pkg::slot_t      slot
);
	import hon_pkg::*;

	slot_t                  slot_q;
	entry_t                 trav_q;
	logic [MAX_LETTERS-1:0] diff;
	logic                   hit;

	always_comb begin
		for (int b = 0; b < MAX_LETTERS; b++) begin
			diff[b] = trav_in.mask[b] &&
				(trav_in.word[b*BYTE_W +: BYTE_W] != slot_q.word[b*BYTE_W +: BYTE_W]);
		end
		hit = trav_in.valid && slot_q.valid && (diff != '0) &&
			((diff & (diff - MAX_LETTERS'(1))) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctl.clear) begin
			slot_q.valid <= 1'b0;
			slot_q.nbr   <= 1'b0;
		end else if (ctl.shift) begin
			slot_q <= next_slot;
		end else if (trav_in.valid) begin
			if (!slot_q.valid) begin
				slot_q.valid <= 1'b1;
				slot_q.nbr   <= trav_in.found;
				slot_q.word  <= trav_in.word;
			end else if (hit) begin
				slot_q.nbr <= 1'b1;
			end
		end
	end

	// pass the word on only if this slot was taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trav_q <= '0;
		end else begin
			trav_q.valid <= trav_in.valid && slot_q.valid && !ctl.clear;
			trav_q.found <= trav_in.found || hit;
			trav_q.mask  <= trav_in.mask;
			trav_q.word  <= trav_in.word;
		end
	end

	assign trav_out = trav_q;
	assign slot     = slot_q;

endmodule

`default_nettype wire

[rtl/hon_chain.sv]
// Row of MAX_WORDS hon_cell slots: words enter at slot 0 and move one
// slot a cycle; shift and rotate move stored words toward slot 0.
// Uses hon_pkg and hon_cell.
`default_nettype none

module hon_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  hon_pkg::chain_ctl_t ctl,
	input  hon_pkg::entry_t     entry,
	output hon_pkg::slot_t      head
);
	import hon_pkg::*;

	slot_t  slots [MAX_WORDS];
	entry_t travs [MAX_WORDS-1];

	for (genvar i = 0; i < MAX_WORDS; i++) begin : g_slot
		entry_t t_in;
		slot_t  nxt;

		if (i == 0) begin : g_first
			assign t_in = entry;
		end else begin : g_rest
			assign t_in = travs[i-1];
		end

		if (i == MAX_WORDS - 1) begin : g_tail
			assign nxt = ctl.rotate ? slots[0] : slot_t'('0);
			hon_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.trav_in  (t_in),
				.trav_out (),
				.next_slot(nxt),
				.slot     (slots[i])
			);
		end else begin : g_body
			assign nxt = slots[i+1];
			hon_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.trav_in  (t_in),
				.trav_out (travs[i]),
				.next_slot(nxt),
				.slot     (slots[i])
			);
		end
	end

	assign head = slots[0];

endmodule

`default_nettype wire

[rtl/hamming_one_neighbor_filter.sv]
// Top level of the one-letter-neighbor word filter: admission of loads,
// finish sequencer, result register. Uses hon_pkg and hon_chain.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  in_data   (hon_pkg::in_req_t)
// out       source     out_valid/out_stall  out_data  (hon_pkg::out_rsp_t)
// cfg       sink       cfg_valid/cfg_ready  cfg_data  (word_length, 4 bits)
//
// Loads are taken one per cycle while idle; each kept word ripples down the
// slot row one slot a cycle, compared with every stored word it passes.
// A finish waits for the row to settle, rotates the row once around to
// count survivors, then walks the row up to the last survivor, dropping
// words without a neighbor and emitting each survivor (one empty result
// if none survives); the walk holds while the result register is stalled.
// Input is stalled from the finish until its last result is registered.
// Reset empties the row, clears the flags and sets word_length to 5.

module hamming_one_neighbor_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hon_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output hon_pkg::out_rsp_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_data
);
	import hon_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WORDS - 1);

	state_t st_q, st_d;
	logic [LEN_W-1:0] word_length_q;
	logic [CNT_W-1:0] admitted_q, admitted_d;
	logic [CNT_W-1:0] surv_q, surv_d;
	logic [CNT_W-1:0] emitted_q, emitted_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             ovf_q, ovf_d;

	logic             out_valid_q;
	out_rsp_t         out_q;
	logic             out_free;
	logic             out_load;
	out_rsp_t         out_next;

	logic                   in_acc;
	logic                   len_ok;
	logic                   is_match;
	logic                   admit;
	logic [MAX_LETTERS-1:0] mask;
	logic [WORD_W-1:0]      bit_mask;
	entry_t                 entry;
	chain_ctl_t             ctl;
	slot_t                  head;
	logic                   head_hit;
	logic                   is_last;

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Admission: a load is kept if its length matches a usable word_length,
	// and dropped (flagging overflow) once the row is full.
	always_comb begin
		mask = byte_mask(word_length_q);
		for (int b = 0; b < MAX_LETTERS; b++) begin
			bit_mask[b*BYTE_W +: BYTE_W] = {BYTE_W{mask[b]}};
		end
	end

	assign len_ok   = (word_length_q != '0) && (word_length_q <= LEN_W'(MAX_LETTERS));
	assign is_match = in_acc && (in_data.operation == OP_LOAD) && len_ok &&
		(in_data.word_letters == word_length_q);
	assign admit    = is_match && (admitted_q < CNT_W'(MAX_WORDS));

	always_comb begin
		entry.valid = admit;
		entry.found = 1'b0;
		entry.mask  = mask;
		entry.word  = WORD_W'({in_data.word_high, in_data.word_low}) & bit_mask;
	end

	hon_chain u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.entry (entry),
		.head  (head)
	);

	assign head_hit = head.valid && head.nbr;
	assign is_last  = (surv_q == '0) || (emitted_q + CNT_W'(1) == surv_q);

	always_comb begin
		out_next.is_word       = (surv_q != '0);
		out_next.out_low       = (surv_q != '0) ? head.word[63:0] : 64'd0;
		out_next.out_high      = (surv_q != '0) ? head.word[79:64] : 16'd0;
		out_next.removed_count = 7'(admitted_q - surv_q);
		out_next.overflowed    = ovf_q;
		out_next.last          = is_last;
	end

	// Finish sequencer: settle, count by rotation, then walk and emit.
	always_comb begin
		st_d       = st_q;
		admitted_d = admitted_q;
		surv_d     = surv_q;
		emitted_d  = emitted_q;
		cnt_d      = cnt_q;
		ovf_d      = ovf_q;
		ctl        = '0;
		out_load   = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (admit) begin
					admitted_d = admitted_q + CNT_W'(1);
				end else if (is_match) begin
					ovf_d = 1'b1;
				end
				if (in_acc && in_data.operation == OP_FINISH) begin
					st_d  = ST_SETTLE;
					cnt_d = '0;
				end
			end
			ST_SETTLE: begin
				cnt_d = cnt_q + IDX_W'(1);
				if (cnt_q == LAST_IDX) begin
					st_d   = ST_COUNT;
					cnt_d  = '0;
					surv_d = '0;
				end
			end
			ST_COUNT: begin
				ctl.shift  = 1'b1;
				ctl.rotate = 1'b1;
				surv_d     = surv_q + CNT_W'(head_hit);
				cnt_d      = cnt_q + IDX_W'(1);
				if (cnt_q == LAST_IDX) begin
					st_d      = ST_EMIT;
					emitted_d = '0;
				end
			end
			ST_EMIT: begin
				if (surv_q != '0 && !head_hit) begin
					// drop a word without a neighbor
					ctl.shift = 1'b1;
				end else if (out_free) begin
					out_load = 1'b1;
					if (is_last) begin
						ctl.clear  = 1'b1;
						admitted_d = '0;
						ovf_d      = 1'b0;
						st_d       = ST_IDLE;
					end else begin
						ctl.shift = 1'b1;
						emitted_d = emitted_q + CNT_W'(1);
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			admitted_q <= '0;
			surv_q     <= '0;
			emitted_q  <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
		end else begin
			st_q       <= st_d;
			admitted_q <= admitted_d;
			surv_q     <= surv_d;
			emitted_q  <= emitted_d;
			cnt_q      <= cnt_d;
			ovf_q      <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q <= LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			word_length_q <= cfg_data;
		end
	end

	// Result register: hold while stalled, advance when taken or empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[tb/hamming_one_neighbor_filter_test.sv]
// Self-checking testbench for the one-letter-neighbor word filter: directed
// word lists, length extremes, a full store and random traffic with idling.
// Depends on hon_pkg and the hamming_one_neighbor_filter top level.
`default_nettype none

module hamming_one_neighbor_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hon_pkg::*;

	// generous bound on the whole run; a correct run needs far fewer cycles
	localparam int CYCLE_LIMIT   = 400000;
	// time for the row to settle and count after a request, with margin
	localparam int SETTLE_CYCLES = 2 * MAX_WORDS + 16;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_req_t    in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_rsp_t   out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data  = '0;

	// behavioral copy of the filter state
	logic [WORD_W-1:0] kept_word [MAX_WORDS];
	logic              kept_linked [MAX_WORDS];
	int                kept_count   = 0;
	logic              dropped_flag = 1'b0;
	logic [LEN_W-1:0]  word_length  = LEN_RESET;

	// survivors still owed by the block, oldest first
	out_rsp_t survivor_queue [$];

	int fail_count    = 0;
	int cycle_count   = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	hamming_one_neighbor_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// stall the result channel at random, changing only on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// one bit set for every bit of the first len letters
	function automatic logic [WORD_W-1:0] letter_mask(input int len);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int b = 0; b < MAX_LETTERS; b++) begin
			if (b < len) m[b*BYTE_W +: BYTE_W] = '1;
		end
		return m;
	endfunction

	// letter i of the text lands in byte i of the word
	function automatic logic [WORD_W-1:0] spell(input string s);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < s.len() && i < MAX_LETTERS; i++) begin
			w[i*BYTE_W +: BYTE_W] = s[i];
		end
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		return {16'($urandom), $urandom, $urandom};
	endfunction

	function automatic in_req_t make_req(input op_t op, input logic [WORD_W-1:0] w,
			input logic [3:0] letters);
		in_req_t r;
		r.operation    = op;
		r.word_low     = w[63:0];
		r.word_high    = w[79:64];
		r.word_letters = letters;
		return r;
	endfunction

	// Advance the filter state by one accepted request and queue the survivors
	// that a finish owes.
	task automatic absorb_request(input in_req_t r);
		logic [WORD_W-1:0] w;
		int                diff;
		int                linked;
		out_rsp_t          rsp;
		if (r.operation == OP_LOAD) begin
			// drop loads of an unusable length or of the wrong length
			if (word_length == 0 || word_length > MAX_LETTERS) return;
			if (r.word_letters != word_length) return;
			// drop loads into a full store, and remember it
			if (kept_count >= MAX_WORDS) begin
				dropped_flag = 1'b1;
				return;
			end
			// clear bytes past the length; they never take part in a compare
			w = {r.word_high, r.word_low} & letter_mask(int'(word_length));
			kept_linked[kept_count] = 1'b0;
			for (int k = 0; k < kept_count; k++) begin
				diff = 0;
				for (int i = 0; i < int'(word_length); i++) begin
					if (kept_word[k][i*BYTE_W +: BYTE_W] != w[i*BYTE_W +: BYTE_W]) diff++;
				end
				// equal words are at distance zero and do not count
				if (diff == 1) begin
					kept_linked[k]          = 1'b1;
					kept_linked[kept_count] = 1'b1;
				end
			end
			kept_word[kept_count] = w;
			kept_count++;
		end else begin
			linked = 0;
			for (int k = 0; k < kept_count; k++) begin
				if (kept_linked[k]) linked++;
			end
			rsp               = '0;
			rsp.removed_count = 7'(kept_count - linked);
			rsp.overflowed    = dropped_flag;
			if (linked == 0) begin
				// nothing survives: one empty result closes the finish
				rsp.last = 1'b1;
				survivor_queue.push_back(rsp);
			end else begin
				for (int k = 0; k < kept_count; k++) begin
					if (kept_linked[k]) begin
						linked--;
						rsp.is_word  = 1'b1;
						rsp.out_low  = kept_word[k][63:0];
						rsp.out_high = kept_word[k][79:64];
						rsp.last     = (linked == 0);
						survivor_queue.push_back(rsp);
					end
				end
			end
			// empty the store after every finish
			kept_count   = 0;
			dropped_flag = 1'b0;
		end
	endtask

	// Compare every accepted result with the oldest owed survivor.
	always @(posedge clk) begin : check_result
		out_rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (survivor_queue.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				fail_count++;
			end else begin
				want = survivor_queue.pop_front();
				if (out_data.is_word !== want.is_word ||
						out_data.out_low !== want.out_low ||
						out_data.out_high !== want.out_high ||
						out_data.removed_count !== want.removed_count ||
						out_data.overflowed !== want.overflowed ||
						out_data.last !== want.last) begin
					$display("%0t: result mismatch, expected %p, actual %p",
						$time, want, out_data);
					fail_count++;
				end
			end
		end
	end

	// Offer one request after a random gap; hold it until it is taken.
	task automatic send_request(input in_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (in_stall);
		absorb_request(r);
	endtask

	// Drop valid and hold off until every owed survivor has come back.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (survivor_queue.size() != 0) @(posedge clk);
	endtask

	// Write the word length while the block is idle.
	task automatic write_length(input logic [3:0] len);
		wait_for_results();
		// let any load still rippling down the row come to rest
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		word_length = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Short hand-built lists at the reset length of five letters.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// finish on an empty store
		send_request(make_req(OP_FINISH, '0, 4'd0));
		// junk above the fifth letter must be cleared
		send_request(make_req(OP_LOAD, spell("aaaaa") | ~letter_mask(5), 4'd5));
		send_request(make_req(OP_LOAD, spell("aaaab"), 4'd5));
		// a duplicate is no neighbor of its twin, but still of aaaaa
		send_request(make_req(OP_LOAD, spell("aaaab"), 4'd5));
		send_request(make_req(OP_LOAD, '1, 4'd5));
		send_request(make_req(OP_LOAD, '0, 4'd5));
		send_request(make_req(OP_LOAD, 80'h01 << 32, 4'd5));
		// loads of other lengths are ignored
		send_request(make_req(OP_LOAD, spell("aaaa"), 4'd4));
		send_request(make_req(OP_LOAD, spell("aaaac"), 4'd0));
		send_request(make_req(OP_LOAD, spell("aaaac"), 4'd15));
		send_request(make_req(OP_LOAD, spell("aaaaccccca"), 4'd10));
		send_request(make_req(OP_LOAD, spell("aaaacc"), 4'd6));
		send_request(make_req(OP_LOAD, spell("zzzzz"), 4'd5));
		// word fields of a finish are don't-care
		send_request(make_req(OP_FINISH, '1, 4'd15));
		wait_for_results();
		// only duplicates: nothing survives
		send_request(make_req(OP_LOAD, spell("hello"), 4'd5));
		send_request(make_req(OP_LOAD, spell("hello"), 4'd5));
		send_request(make_req(OP_FINISH, '0, 4'd5));
		wait_for_results();
	endtask

	// Shortest and longest usable lengths, then the unusable ones.
	task automatic test_length_extremes();
		write_length(4'd1);
		send_request(make_req(OP_LOAD, ~letter_mask(1), 4'd1));
		send_request(make_req(OP_LOAD, 80'hFF, 4'd1));
		send_request(make_req(OP_LOAD, '0, 4'd1));
		send_request(make_req(OP_FINISH, random_word(), 4'd1));
		write_length(4'd10);
		send_request(make_req(OP_LOAD, spell("abcdefghij"), 4'd10));
		send_request(make_req(OP_LOAD, spell("abcdefghiX"), 4'd10));
		send_request(make_req(OP_LOAD, spell("abcdefghYj"), 4'd10));
		send_request(make_req(OP_LOAD, spell("ABCDEFGHIJ"), 4'd10));
		send_request(make_req(OP_LOAD, '1, 4'd10));
		send_request(make_req(OP_LOAD, {{(WORD_W-BYTE_W){1'b1}}, 8'h00}, 4'd10));
		send_request(make_req(OP_FINISH, random_word(), 4'd10));
		// a zero length keeps nothing, whatever the load says
		write_length(4'd0);
		send_request(make_req(OP_LOAD, spell("a"), 4'd0));
		send_request(make_req(OP_LOAD, spell("abcde"), 4'd5));
		send_request(make_req(OP_FINISH, random_word(), 4'd0));
		// so does a length past the longest word
		write_length(4'd15);
		send_request(make_req(OP_LOAD, random_word(), 4'd15));
		send_request(make_req(OP_LOAD, random_word(), 4'd15));
		send_request(make_req(OP_FINISH, random_word(), 4'd15));
		wait_for_results();
	endtask

	// Overfill the store, then check that a second finish clears the flag.
	task automatic test_store_full();
		logic [WORD_W-1:0] w;
		write_length(4'd2);
		for (int n = 0; n < MAX_WORDS + 3; n++) begin
			w          = random_word();
			w[7:0]     = 8'h61 + 8'($urandom_range(2));
			w[15:8]    = 8'h61 + 8'($urandom_range(2));
			send_request(make_req(OP_LOAD, w, 4'd2));
		end
		send_request(make_req(OP_FINISH, random_word(), 4'd2));
		send_request(make_req(OP_FINISH, random_word(), 4'd2));
		wait_for_results();
	endtask

	// One list of loads closed by a finish. Most loads copy an earlier word and
	// change one letter (two for a near miss), some repeat it, the rest are
	// fresh words or loads of a random length.
	task automatic send_word_group(inout int counted);
		logic [WORD_W-1:0] group [$];
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] w;
		logic [3:0]        letters;
		int                size;
		int                pick;
		int                pos;
		int                len;
		len  = int'(word_length);
		mask = letter_mask(len);
		size = ($urandom_range(11) == 0) ? $urandom_range(60, MAX_WORDS + 4)
			: $urandom_range(0, 12);
		for (int n = 0; n < size; n++) begin
			pick    = $urandom_range(99);
			letters = 4'(len);
			w       = random_word();
			if (group.size() != 0 && pick < 60) begin
				w = (group[$urandom_range(group.size() - 1)] & mask) | (w & ~mask);
				if (pick < 50) begin
					pos = $urandom_range(len - 1);
					w[pos*BYTE_W +: BYTE_W] ^= 8'($urandom_range(1, 255));
					if (pick < 10 && len > 1) begin
						pos = (pos + $urandom_range(1, len - 1)) % len;
						w[pos*BYTE_W +: BYTE_W] ^= 8'($urandom_range(1, 255));
					end
				end
			end else if (pick >= 88) begin
				letters = 4'($urandom_range(15));
			end
			send_request(make_req(OP_LOAD, w, letters));
			if (letters == len) begin
				counted++;
				group.push_back(w);
			end
		end
		send_request(make_req(OP_FINISH, random_word(), 4'($urandom_range(15))));
		counted++;
	endtask

	// Random lists in three idling phases, with length changes in between.
	task automatic test_random_traffic();
		int phase_items;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 83 : 0;
			recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 31 : 0;
			phase_items   = 0;
			while (phase_items < 30) begin
				if ($urandom_range(3) == 0) begin
					write_length(4'($urandom_range(1, MAX_LETTERS)));
				end
				send_word_group(phase_items);
				// now and then hold the sender until the finish has drained
				if ($urandom_range(5) == 0) wait_for_results();
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_length_extremes();
		test_store_full();
		test_random_traffic();
		wait_for_results();
		// watch for stray results after the last one owed
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

[hamming_one_neighbor_filter.f]
rtl/hon_pkg.sv
rtl/hon_cell.sv
rtl/hon_chain.sv
rtl/hamming_one_neighbor_filter.sv
tb/hamming_one_neighbor_filter_test.sv
